@@ rtl/sfr_pkg.sv @@
// shared types and codes for the stuffed frame receiver
// no dependencies; imported by every module of the block
package sfr_pkg;

   // framing bytes
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] STUFF_ESC = 8'h7D;
   localparam logic [7:0] ESC_MASK  = 8'h20;
   localparam logic [7:0] CTRL_SEQ0 = 8'h00;
   localparam logic [7:0] CTRL_SEQ1 = 8'h20;
   localparam logic [7:0] ADDR_RESET = 8'h03;

   // parser phase codes
   localparam logic [2:0] PH_HUNT   = 3'd0;
   localparam logic [2:0] PH_ADDR   = 3'd1;
   localparam logic [2:0] PH_CTRL   = 3'd2;
   localparam logic [2:0] PH_HCS    = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_ESC    = 3'd5;
   localparam logic [2:0] PH_SUPEND = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_GOOD = 2'd1;
   localparam logic [1:0] KIND_BAD  = 2'd2;
   localparam logic [1:0] KIND_SUP  = 2'd3;

   // one result word
   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       seq_bit;
      logic       frame_last;
   } result_type;

endpackage

@@ rtl/stuffed_frame_receiver.sv @@
// byte-stuffed link frame receiver: input register, combinational parser step, result
// register; throughput one byte per cycle while the result is not stalled, set by the
// single-pass parser step between the two registers; a stalled result holds the
// parser, so the input stalls as soon as its one-byte register is full
// synchronous active-high reset: hunt for flag, address register back to 0x03
// depends on sfr_pkg, sfr_in_stage, sfr_parser, sfr_out_stage
module stuffed_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_seq_bit,
   output logic       rsp_frame_last
);
   import sfr_pkg::*;

   logic       advance;
   logic       byte_valid;
   logic [7:0] byte_data;
   logic       fire;
   logic       res_valid;
   result_type res;
   result_type rsp_word;

   assign fire = byte_valid & advance;

   // input register
   sfr_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   // parser step
   sfr_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fire           (fire),
      .rx_byte        (byte_data),
      .res_valid      (res_valid),
      .res            (res)
   );

   // result register
   sfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   assign rsp_out_kind   = rsp_word.out_kind;
   assign rsp_out_byte   = rsp_word.out_byte;
   assign rsp_seq_bit    = rsp_word.seq_bit;
   assign rsp_frame_last = rsp_word.frame_last;

endmodule

@@ rtl/sfr_in_stage.sv @@
// input register for raw received bytes
// depends on sfr_pkg
module sfr_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   import sfr_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;
   logic       fire;

   // hold a word only while the parser cannot take it
   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign fire      = valid_ff & advance;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

@@ rtl/sfr_parser.sv @@
// frame parser: phase tracking, unstuffing, check byte and frame status
// depends on sfr_pkg
module sfr_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [7:0]          csr_write_data,
   input  logic                fire,
   input  logic [7:0]          rx_byte,
   output logic                res_valid,
   output sfr_pkg::result_type res
);
   import sfr_pkg::*;

   logic [7:0] addr_ff;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] ctrl_ff, ctrl_in;
   logic       seq_ff, seq_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] held_ff, held_in;
   logic       held_valid_ff, held_valid_in;

   logic       is_flag;
   logic [7:0] data_byte;
   logic       take;
   logic       close;
   logic       close_ok;

   assign is_flag = (rx_byte == FLAG_BYTE);

   // address register
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= ADDR_RESET;
      end else if (csr_write_en) begin
         addr_ff <= csr_write_data;
      end
   end

   // next phase and which action the byte triggers
   always_comb begin
      phase_in  = phase_ff;
      ctrl_in   = ctrl_ff;
      seq_in    = seq_ff;
      take      = 1'b0;
      close     = 1'b0;
      close_ok  = 1'b0;
      data_byte = rx_byte;
      res_valid = 1'b0;
      res       = '0;
      unique case (phase_ff)
         PH_ADDR: begin
            if (rx_byte == addr_ff) begin
               phase_in = PH_CTRL;
            end else if (!is_flag) begin
               phase_in = PH_HUNT;
            end
         end
         PH_CTRL: begin
            if (is_flag) begin
               phase_in = PH_ADDR;
            end else begin
               ctrl_in  = rx_byte;
               phase_in = PH_HCS;
            end
         end
         PH_HCS: begin
            if (rx_byte == (addr_ff ^ ctrl_ff)) begin
               if (ctrl_ff == CTRL_SEQ0 || ctrl_ff == CTRL_SEQ1) begin
                  seq_in   = ctrl_ff[5];
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_SUPEND;
               end
            end else begin
               phase_in = is_flag ? PH_ADDR : PH_HUNT;
            end
         end
         PH_DATA: begin
            if (is_flag) begin
               close    = 1'b1;
               close_ok = held_valid_ff & (held_ff == xor_ff);
            end else if (rx_byte == STUFF_ESC) begin
               phase_in = PH_ESC;
            end else begin
               take = 1'b1;
            end
         end
         PH_ESC: begin
            if (is_flag) begin
               close = 1'b1;
            end else begin
               phase_in  = PH_DATA;
               take      = 1'b1;
               data_byte = rx_byte ^ ESC_MASK;
            end
         end
         PH_SUPEND: begin
            if (is_flag) begin
               res_valid      = 1'b1;
               res.out_kind   = KIND_SUP;
               res.out_byte   = ctrl_ff;
               res.frame_last = 1'b1;
               phase_in       = PH_ADDR;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         default: begin
            phase_in = is_flag ? PH_ADDR : PH_HUNT;
         end
      endcase

      // info frame close
      if (close) begin
         res_valid      = 1'b1;
         res.out_kind   = close_ok ? KIND_GOOD : KIND_BAD;
         res.out_byte   = ctrl_ff;
         res.seq_bit    = seq_ff;
         res.frame_last = 1'b1;
         phase_in       = PH_ADDR;
      end

      // data byte releases the one held back
      if (take && held_valid_ff) begin
         res_valid    = 1'b1;
         res.out_kind = KIND_DATA;
         res.out_byte = held_ff;
         res.seq_bit  = seq_ff;
      end
   end

   // payload check and hold-back register
   always_comb begin
      xor_in        = xor_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      if (close || (phase_ff == PH_HCS && phase_in != PH_HUNT
                    && phase_in != PH_ADDR)) begin
         xor_in        = '0;
         held_in       = '0;
         held_valid_in = 1'b0;
      end else if (take) begin
         if (held_valid_ff) begin
            xor_in = xor_ff ^ held_ff;
         end
         held_in       = data_byte;
         held_valid_in = 1'b1;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         ctrl_ff       <= '0;
         seq_ff        <= 1'b0;
         xor_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         ctrl_ff       <= ctrl_in;
         seq_ff        <= seq_in;
         xor_ff        <= xor_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

@@ rtl/sfr_out_stage.sv @@
// result register toward the consumer
// depends on sfr_pkg
module sfr_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                res_valid,
   input  sfr_pkg::result_type res,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sfr_pkg::result_type rsp_word
);
   import sfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type word_ff;

   // parser may step when the slot is empty or being taken
   assign advance = ~valid_ff | ~rsp_stall;

   always_comb begin
      if (fire) begin
         valid_in = res_valid;
      end else begin
         valid_in = valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         word_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule
